// File: design/sdl_pkg.sv
`timescale 1ns / 1ps

package sdl_pkg;

   localparam logic [31:0] SYNC_RESET = 32'h2EFC_9827;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'h0000;
   localparam int          IDX_W      = 17;
   localparam logic [IDX_W-1:0] MIN_FRAME = IDX_W'(18);
   localparam logic [IDX_W-1:0] HDR_BYTES = IDX_W'(16);
   localparam logic [IDX_W-1:0] IDX_SIZE_LO = IDX_W'(16);
   localparam logic [IDX_W-1:0] IDX_SIZE_HI = IDX_W'(17);
   localparam logic [IDX_W-1:0] IDX_CRC_START = IDX_W'(2);
   localparam int          DATA_W     = 48;

   // sliced bit handed from the input register to the frame core
   typedef struct packed {
      logic valid;
      logic sample_bit;
   } sdl_bit_type;

   // CRC-16, MSB first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: design/sdl_in_stage.sv
`timescale 1ns / 1ps

module sdl_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                take,
   output sdl_pkg::sdl_bit_type bit_out
);
   import sdl_pkg::*;

   logic valid_ff, valid_in;
   logic bit_ff, bit_in;
   logic slice;

   // positive sample: sign clear and not zero
   assign slice      = ~req_tdata[7] & (|req_tdata[6:0]);
   assign req_tready = ~valid_ff | take;

   always_comb begin
      valid_in = valid_ff;
      bit_in   = bit_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         bit_in   = slice;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bit_ff <= bit_in;
   end

   assign bit_out.valid      = valid_ff;
   assign bit_out.sample_bit = bit_ff;

endmodule

// File: design/sdl_core.sv
`timescale 1ns / 1ps

module sdl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  sdl_pkg::sdl_bit_type bit_in_s,
   output logic                 take,
   input  logic [31:0]          sync_word,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [sdl_pkg::DATA_W-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);
   import sdl_pkg::*;

   logic [31:0]      sync_ff, sync_in;
   logic             in_frame_ff, in_frame_in;
   logic [2:0]       bc_ff, bc_in;
   logic [7:0]       byte_ff, byte_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      size_ff, size_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       d0_ff, d0_in, d1_ff, d1_in;

   logic             rv_ff, rv_in;
   logic [7:0]       r_byte_ff, r_byte_in;
   logic [IDX_W-1:0] r_idx_ff, r_idx_in, r_len_ff, r_len_in;
   logic             r_last_ff, r_last_in, r_ok_ff, r_ok_in;

   logic             consume;
   logic [IDX_W-1:0] len_raw;
   logic [IDX_W:0]   idx_p1;
   logic [15:0]      crc_upd;

   assign take    = ~rv_ff | rsp_tready;
   assign consume = bit_in_s.valid & take;
   assign idx_p1  = {1'b0, idx_ff} + 1'b1;
   assign crc_upd = crc_byte(crc_ff, d1_ff);

   always_comb begin
      sync_in     = sync_ff;
      in_frame_in = in_frame_ff;
      bc_in       = bc_ff;
      byte_in     = byte_ff;
      idx_in      = idx_ff;
      size_in     = size_ff;
      crc_in      = crc_ff;
      d0_in       = d0_ff;
      d1_in       = d1_ff;
      rv_in       = rv_ff & ~rsp_tready;
      r_byte_in   = r_byte_ff;
      r_idx_in    = r_idx_ff;
      r_len_in    = r_len_ff;
      r_last_in   = r_last_ff;
      r_ok_in     = r_ok_ff;
      len_raw     = '0;
      if (consume) begin
         sync_in = {sync_ff[30:0], bit_in_s.sample_bit};
         if (!in_frame_ff) begin
            if (sync_in == sync_word) begin
               in_frame_in = 1'b1;
               bc_in       = '0;
               idx_in      = '0;
               size_in     = '0;
               crc_in      = CRC_INIT;
               d0_in       = '0;
               d1_in       = '0;
            end
         end else begin
            byte_in = {byte_ff[6:0], bit_in_s.sample_bit};
            bc_in   = bc_ff + 1'b1;
            if (bc_in == 3'd0) begin
               if (idx_ff == IDX_SIZE_LO) begin
                  size_in = {size_ff[15:8], byte_in};
               end else if (idx_ff == IDX_SIZE_HI) begin
                  size_in = {byte_in, size_ff[7:0]};
               end
               r_len_in = '0;
               if (idx_ff >= IDX_SIZE_HI) begin
                  len_raw  = {1'b0, size_in} + HDR_BYTES;
                  r_len_in = (len_raw < MIN_FRAME) ? MIN_FRAME : len_raw;
               end
               if (idx_ff >= IDX_CRC_START) begin
                  crc_in = crc_upd;
               end
               r_last_in = (idx_ff >= IDX_SIZE_HI) && (idx_p1 >= {1'b0, r_len_in});
               r_ok_in   = r_last_in && ({byte_in, d0_ff} == crc_in);
               r_byte_in = byte_in;
               r_idx_in  = idx_ff;
               rv_in     = 1'b1;
               d1_in     = d0_ff;
               d0_in     = byte_in;
               idx_in    = idx_p1[IDX_W-1:0];
               if (r_last_in) begin
                  in_frame_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= '0;
         in_frame_ff <= 1'b0;
         bc_ff       <= '0;
         byte_ff     <= '0;
         idx_ff      <= '0;
         size_ff     <= '0;
         crc_ff      <= CRC_INIT;
         d0_ff       <= '0;
         d1_ff       <= '0;
         rv_ff       <= 1'b0;
      end else begin
         sync_ff     <= sync_in;
         in_frame_ff <= in_frame_in;
         bc_ff       <= bc_in;
         byte_ff     <= byte_in;
         idx_ff      <= idx_in;
         size_ff     <= size_in;
         crc_ff      <= crc_in;
         d0_ff       <= d0_in;
         d1_ff       <= d1_in;
         rv_ff       <= rv_in;
      end
      r_byte_ff <= r_byte_in;
      r_idx_ff  <= r_idx_in;
      r_len_ff  <= r_len_in;
      r_last_ff <= r_last_in;
      r_ok_ff   <= r_ok_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {{(DATA_W - 8 - 2*IDX_W){1'b0}}, r_len_ff, r_idx_ff, r_byte_ff};
   assign rsp_tlast  = r_last_ff;
   assign rsp_tuser  = r_ok_ff;

endmodule

// File: design/sync_deframer_length_crc16.sv
`timescale 1ns / 1ps

// Sync-word deframer with length field and CRC-16 check. Each req_
// transaction carries one signed soft sample; it is sliced to a bit (one when
// the sample is above zero) and shifted into a 32-bit sync register. Outside a
// frame a match against the sync word (csr_, reset 0x2EFC9827) opens a frame;
// the matching bit itself is not frame data. Frame bits are packed MSB first
// and every completed byte leaves as one rsp_ transaction with its index.
// Bytes 16/17 are a little-endian size; the frame is max(size+16, 18) bytes.
// CRC-16 (poly 0x1021, init 0, no reflection, no final xor) runs over all but
// the last two bytes, which hold the received CRC little-endian; the last
// byte carries rsp_tlast and the verdict in rsp_tuser. Rate: one sample per
// clock sustained while rsp_tready keeps taking results. The sample lands
// in the input register at the accepting edge; its byte, if it completes
// one, then moves into the result register with rsp_tvalid high. A result
// held by rsp_tready low stops the core; req_tready then drops once the
// input register is full.
// Write csr_ only while the block is idle: no sample held, no result waiting.
module sync_deframer_length_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] soft_sample (signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] frame_byte, [24:8] byte_index,
                                    // [41:25] frame_length, [47:42] zero
   output logic        rsp_tlast,   // last_byte
   output logic        rsp_tuser,   // crc_ok
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // sync_word
);
   import sdl_pkg::*;

   logic [31:0] sync_word_ff, sync_word_in;
   sdl_bit_type bit_s;
   logic        take;

   // config always accepted; the user must write it only while idle, the block does not enforce this
   assign csr_ready    = 1'b1;
   assign sync_word_in = (csr_valid & csr_ready) ? csr_data : sync_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= SYNC_RESET;
      end else begin
         sync_word_ff <= sync_word_in;
      end
   end

   // slicer and input register
   sdl_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .bit_out    (bit_s)
   );

   // sync search, byte packing, length, CRC and result register
   sdl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .bit_in_s   (bit_s),
      .take       (take),
      .sync_word  (sync_word_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/sdl_checker.sv
`timescale 1ns / 1ps

module sdl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   logic [16:0] idx_w, len_w;

   assign idx_w    = rsp_tdata[24:8];
   assign len_w    = rsp_tdata[41:25];

   a_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("crc verdict on a byte that is not last");

   a_len_early_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (idx_w < 17'd17) |-> (len_w == 17'd0) && !rsp_tlast)
      else $error("length or last before size is known");

   a_last_at_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> ({1'b0, idx_w} + 18'd1 == {1'b0, len_w}) && (len_w >= 17'd18))
      else $error("last byte does not match frame length");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // with no result waiting the core never holds the input back
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result waiting");

endmodule

bind sync_deframer_length_crc16 sdl_checker u_sdl_checker (.*);
